>>> rtl/vpcu_pkg.sv
// Shared types, register indexes, reset values and direction helpers for the
// ViBe pixel classify and update block. Used by the controller, datapath and top.
`timescale 1ns / 1ps
`default_nettype none

package vpcu_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_MATCH_RADIUS   = 3'd0;
    localparam logic [2:0] REG_MIN_MATCHES    = 3'd1;
    localparam logic [2:0] REG_SUBSAMPLE_LOG2 = 3'd2;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd3;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_BG_VALUE       = 3'd5;
    localparam logic [2:0] REG_FG_VALUE       = 3'd6;

    // Register reset values.
    localparam logic [7:0] RST_MATCH_RADIUS   = 8'd20;
    localparam logic [4:0] RST_MIN_MATCHES    = 5'd2;
    localparam logic [3:0] RST_SUBSAMPLE_LOG2 = 4'd4;
    localparam logic [7:0] RST_FRAME_WIDTH    = 8'd128;
    localparam logic [7:0] RST_FRAME_HEIGHT   = 8'd128;
    localparam logic [7:0] RST_BG_VALUE       = 8'd0;
    localparam logic [7:0] RST_FG_VALUE       = 8'd255;

    // Neighbour direction codes, clockwise from upper left.
    localparam logic [2:0] DIR_UP_LEFT    = 3'd0;
    localparam logic [2:0] DIR_UP         = 3'd1;
    localparam logic [2:0] DIR_UP_RIGHT   = 3'd2;
    localparam logic [2:0] DIR_RIGHT      = 3'd3;
    localparam logic [2:0] DIR_DOWN_RIGHT = 3'd4;
    localparam logic [2:0] DIR_DOWN       = 3'd5;
    localparam logic [2:0] DIR_DOWN_LEFT  = 3'd6;
    localparam logic [2:0] DIR_LEFT       = 3'd7;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_COUNT,
        S_DECIDE,
        S_NBR,
        S_EMIT
    } t_state;

    // Step of one neighbour coordinate.
    typedef enum logic [1:0] {
        MV_STAY,
        MV_DEC,
        MV_INC
    } t_move;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic load_wr;
        logic read;
        logic count;
        logic self_wr;
        logic nbr_wr;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_load;
        logic is_bg;
        logic self_hit;
        logic nbr_hit;
        logic out_busy;
    } t_status;

    // Column step for a neighbour direction.
    function automatic t_move dir_dx(logic [2:0] dir);
        t_move m;
        case (dir)
            DIR_UP_LEFT, DIR_DOWN_LEFT, DIR_LEFT:     m = MV_DEC;
            DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT:  m = MV_INC;
            default:                                  m = MV_STAY;
        endcase
        return m;
    endfunction

    // Row step for a neighbour direction.
    function automatic t_move dir_dy(logic [2:0] dir);
        t_move m;
        case (dir)
            DIR_UP_LEFT, DIR_UP, DIR_UP_RIGHT:        m = MV_DEC;
            DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT:  m = MV_INC;
            default:                                  m = MV_STAY;
        endcase
        return m;
    endfunction

    // Steps a coordinate that is already inside [0, lim-1] and keeps it there.
    function automatic logic [6:0] move_coord(logic [6:0] c, t_move m, logic [7:0] lim);
        logic [6:0] r;
        case (m)
            MV_DEC:  r = (c == 7'd0) ? c : c - 7'd1;
            MV_INC:  r = ({1'b0, c} == lim - 8'd1) ? c : c + 7'd1;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vibe_pixel_classify_update.sv
// Top level of the ViBe pixel classify and update block: joins controller
// and datapath and holds the checks. Depends on vpcu_pkg, vpcu_ctrl, vpcu_datapath.
`timescale 1ns / 1ps
`default_nettype none

// One input word carries a gray pixel with its position and random draws and
// produces one mask word. The block works on one word at a time: a load word
// goes through accept, write all samples and hand off. A classify word goes
// through accept, a registered read, a registered match count, the decision
// with the own sample write, a neighbour write when a neighbour sample is
// written, and hand off, since the single write port of the sample memory
// takes the own and the neighbour write one after the other. The hand-off
// cycle stretches for as long as the previous mask word is still held in the
// output register. A finished mask word waits in the output register while
// the next word is accepted. The sample memory holds one word per pixel with
// one byte lane per sample and is not cleared; a pixel must be loaded before
// it is classified. Configuration writes are always taken at once outside reset.
module vibe_pixel_classify_update #(
    parameter int SAMPLES    = 20,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_load_first,
    input  wire logic [7:0]  i_pixel,
    input  wire logic [6:0]  i_col,
    input  wire logic [6:0]  i_row,
    input  wire logic [15:0] i_self_draw,
    input  wire logic [4:0]  i_self_slot,
    input  wire logic [15:0] i_nbr_draw,
    input  wire logic [2:0]  i_nbr_dir,
    input  wire logic [4:0]  i_nbr_slot,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_mask_value,
    output logic             o_is_foreground
);

    vpcu_pkg::t_cmd    w_cmd;
    vpcu_pkg::t_status w_status;

    // Controller.
    vpcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    vpcu_datapath #(
        .SAMPLES    (SAMPLES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_load_first    (i_load_first),
        .i_pixel         (i_pixel),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_self_draw     (i_self_draw),
        .i_self_slot     (i_self_slot),
        .i_nbr_draw      (i_nbr_draw),
        .i_nbr_dir       (i_nbr_dir),
        .i_nbr_slot      (i_nbr_slot),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_mask_value    (o_mask_value),
        .o_is_foreground (o_is_foreground)
    );

    // At most one memory access per cycle on the single port.
    a_one_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_wr, w_cmd.read, w_cmd.self_wr, w_cmd.nbr_wr}))
        else $error("more than one sample memory access in a cycle");

    // A result is never handed over while the previous one is still held.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(o_out_valid && !i_out_ready))
        else $error("result word overwrote a pending output word");

    // An accepted word blocks further input while it is in progress.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after acceptance");

    // The match count always follows the registered read.
    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.read |=> w_cmd.count)
        else $error("match count did not follow the sample read");

endmodule

`default_nettype wire

>>> rtl/vpcu_ctrl.sv
// Controller state machine of the ViBe pixel block: sequences read, count,
// decision, sample writes and result hand-off. Depends on vpcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpcu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire vpcu_pkg::t_status i_status,
    output vpcu_pkg::t_cmd        o_cmd
);

    vpcu_pkg::t_state r_state;
    vpcu_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vpcu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            vpcu_pkg::S_IDLE: begin
                // No word is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_status.in_load ? vpcu_pkg::S_LOAD : vpcu_pkg::S_READ;
                end
            end
            vpcu_pkg::S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state = vpcu_pkg::S_EMIT;
            end
            vpcu_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state = vpcu_pkg::S_COUNT;
            end
            vpcu_pkg::S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state = vpcu_pkg::S_DECIDE;
            end
            vpcu_pkg::S_DECIDE: begin
                o_cmd.self_wr = i_status.is_bg && i_status.self_hit;
                n_state = (i_status.is_bg && i_status.nbr_hit) ? vpcu_pkg::S_NBR
                                                               : vpcu_pkg::S_EMIT;
            end
            vpcu_pkg::S_NBR: begin
                o_cmd.nbr_wr = 1'b1;
                n_state = vpcu_pkg::S_EMIT;
            end
            vpcu_pkg::S_EMIT: begin
                // Hand the result over once the output register is free.
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = vpcu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vpcu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/vpcu_datapath.sv
// Datapath of the ViBe pixel block: configuration registers, address math,
// the wide sample memory, match counting and the output register. Uses vpcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpcu_datapath #(
    parameter int SAMPLES    = 20,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vpcu_pkg::t_cmd    i_cmd,
    output vpcu_pkg::t_status      o_status,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_load_first,
    input  wire logic [7:0]        i_pixel,
    input  wire logic [6:0]        i_col,
    input  wire logic [6:0]        i_row,
    input  wire logic [15:0]       i_self_draw,
    input  wire logic [4:0]        i_self_slot,
    input  wire logic [15:0]       i_nbr_draw,
    input  wire logic [2:0]        i_nbr_dir,
    input  wire logic [4:0]        i_nbr_slot,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_mask_value,
    output logic                   o_is_foreground
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SAMPLES + 1);

    // Configuration registers.
    logic [7:0] r_match_radius;
    logic [4:0] r_min_matches;
    logic [3:0] r_subsample_log2;
    logic [7:0] r_frame_width;
    logic [7:0] r_frame_height;
    logic [7:0] r_bg_value;
    logic [7:0] r_fg_value;

    // Writes are taken at once, except while reset is held.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_radius   <= vpcu_pkg::RST_MATCH_RADIUS;
            r_min_matches    <= vpcu_pkg::RST_MIN_MATCHES;
            r_subsample_log2 <= vpcu_pkg::RST_SUBSAMPLE_LOG2;
            r_frame_width    <= vpcu_pkg::RST_FRAME_WIDTH;
            r_frame_height   <= vpcu_pkg::RST_FRAME_HEIGHT;
            r_bg_value       <= vpcu_pkg::RST_BG_VALUE;
            r_fg_value       <= vpcu_pkg::RST_FG_VALUE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vpcu_pkg::REG_MATCH_RADIUS:   r_match_radius   <= i_cfg_data;
                vpcu_pkg::REG_MIN_MATCHES:    r_min_matches    <= i_cfg_data[4:0];
                vpcu_pkg::REG_SUBSAMPLE_LOG2: r_subsample_log2 <= i_cfg_data[3:0];
                vpcu_pkg::REG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data;
                vpcu_pkg::REG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data;
                vpcu_pkg::REG_BG_VALUE:       r_bg_value       <= i_cfg_data;
                vpcu_pkg::REG_FG_VALUE:       r_fg_value       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame size saturated into [1, MAX].
    logic [7:0] frame_w;
    logic [7:0] frame_h;

    always_comb begin
        if (r_frame_width == 8'd0) begin
            frame_w = 8'd1;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            frame_w = 8'(MAX_WIDTH);
        end else begin
            frame_w = r_frame_width;
        end
        if (r_frame_height == 8'd0) begin
            frame_h = 8'd1;
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            frame_h = 8'(MAX_HEIGHT);
        end else begin
            frame_h = r_frame_height;
        end
    end

    // Own and neighbour positions, from the input word at acceptance.
    logic [6:0]    col_c;
    logic [6:0]    row_c;
    logic [6:0]    nbr_col;
    logic [6:0]    nbr_row;
    logic [15:0]   self_prod;
    logic [15:0]   nbr_prod;
    logic [AW-1:0] self_pos;
    logic [AW-1:0] nbr_pos;
    logic [15:0]   upd_mask;
    logic [SAMPLES-1:0] self_lanes;
    logic [SAMPLES-1:0] nbr_lanes;

    always_comb begin
        col_c = ({1'b0, i_col} >= frame_w) ? 7'(frame_w - 8'd1) : i_col;
        row_c = ({1'b0, i_row} >= frame_h) ? 7'(frame_h - 8'd1) : i_row;
        nbr_col = vpcu_pkg::move_coord(col_c, vpcu_pkg::dir_dx(i_nbr_dir), frame_w);
        nbr_row = vpcu_pkg::move_coord(row_c, vpcu_pkg::dir_dy(i_nbr_dir), frame_h);
        self_prod = 16'(row_c) * 16'(frame_w);
        nbr_prod  = 16'(nbr_row) * 16'(frame_w);
        self_pos  = AW'(self_prod + 16'(col_c));
        nbr_pos   = AW'(nbr_prod + 16'(nbr_col));
        upd_mask  = (16'd1 << r_subsample_log2) - 16'd1;
        // A slot of SAMPLES or more selects no lane.
        for (int s = 0; s < SAMPLES; s++) begin
            self_lanes[s] = (i_self_slot == 5'(s));
            nbr_lanes[s]  = (i_nbr_slot == 5'(s));
        end
    end

    // Word registers for the item in progress.
    logic               r_load;
    logic [7:0]         r_pixel;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_npos;
    logic               r_self_hit;
    logic               r_nbr_hit;
    logic [SAMPLES-1:0] r_self_lanes;
    logic [SAMPLES-1:0] r_nbr_lanes;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_load       <= i_load_first;
            r_pixel      <= i_pixel;
            r_pos        <= self_pos;
            r_npos       <= nbr_pos;
            r_self_hit   <= (i_self_draw & upd_mask) == 16'd0;
            r_nbr_hit    <= (i_nbr_draw & upd_mask) == 16'd0;
            r_self_lanes <= self_lanes;
            r_nbr_lanes  <= nbr_lanes;
        end
    end

    // Sample memory: one word holds all samples of one pixel, byte lanes per sample.
    logic [SAMPLES*8-1:0] r_mem [DEPTH];
    logic [SAMPLES*8-1:0] r_rdata;
    logic [SAMPLES-1:0]   wr_lanes;
    logic [AW-1:0]        wr_addr;

    always_comb begin
        wr_addr = i_cmd.nbr_wr ? r_npos : r_pos;
        if (i_cmd.load_wr) begin
            wr_lanes = '1;
        end else if (i_cmd.self_wr) begin
            wr_lanes = r_self_lanes;
        end else if (i_cmd.nbr_wr) begin
            wr_lanes = r_nbr_lanes;
        end else begin
            wr_lanes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SAMPLES; s++) begin
            if (wr_lanes[s]) begin
                r_mem[wr_addr][s*8 +: 8] <= r_pixel;
            end
        end
        if (i_cmd.read) begin
            r_rdata <= r_mem[r_pos];
        end
    end

    // Per-sample match test and registered match count.
    logic [SAMPLES-1:0] match;
    logic [CW-1:0]      r_count;
    logic               is_bg;

    always_comb begin
        for (int s = 0; s < SAMPLES; s++) begin
            logic [7:0] v;
            logic [7:0] d;
            v = r_rdata[s*8 +: 8];
            d = (r_pixel > v) ? r_pixel - v : v - r_pixel;
            match[s] = d < r_match_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count) begin
            r_count <= CW'($countones(match));
        end
    end

    assign is_bg = 32'(r_count) >= 32'(r_min_matches);

    // Output register, separate from the work path.
    logic       r_out_valid;
    logic [7:0] r_mask_value;
    logic       r_is_fg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mask_value <= (r_load || is_bg) ? r_bg_value : r_fg_value;
            r_is_fg      <= !r_load && !is_bg;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mask_value    = r_mask_value;
    assign o_is_foreground = r_is_fg;

    // Status toward the controller.
    always_comb begin
        o_status.in_load  = i_load_first;
        o_status.is_bg    = is_bg;
        o_status.self_hit = r_self_hit;
        o_status.nbr_hit  = r_nbr_hit;
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire
